>>> src/lbp_pkg.sv
// Shared types, constants and helpers for the 3x3 local binary pattern stream block.
// No dependencies; imported by the top level and its checker.
package lbp_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int PIX_W       = 8;
    localparam int DIM_W       = 11;
    localparam int POS_W       = 10;
    localparam int CLASS_W     = 4;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int NEIGHBOUR_COUNT = 8;

    // Configuration register indexes
    localparam logic [1:0] CFG_TOLERANCE    = 2'd0;
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

    // Class reported for an all-zero or all-one pattern
    localparam logic [CLASS_W-1:0] CLASS_FLAT = CLASS_W'(NEIGHBOUR_COUNT);
    localparam logic [CLASS_W-1:0] CLASS_NONUNIFORM = '0;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [POS_W-1:0] t_pos;
    typedef logic [DIM_W-1:0] t_dim;

    function automatic logic [CLASS_W-1:0] popcount8(input logic [7:0] v);
        logic [CLASS_W-1:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + CLASS_W'(v[i]);
        end
        return n;
    endfunction

    // One circular run of ones gives its length, flat patterns give 8, the rest 0
    function automatic logic [CLASS_W-1:0] uniform_class(input logic [7:0] code);
        logic [7:0] rot;
        logic [CLASS_W-1:0] edges;
        logic [CLASS_W-1:0] cls;
        rot   = {code[6:0], code[7]};
        edges = popcount8(code ^ rot);
        if (code == 8'h00 || code == 8'hFF) begin
            cls = CLASS_FLAT;
        end else if (edges == CLASS_W'(2)) begin
            cls = popcount8(code);
        end else begin
            cls = CLASS_NONUNIFORM;
        end
        return cls;
    endfunction

endpackage

>>> src/lbp_3x3_descriptor_stream_top.sv
// Top level of the 3x3 local binary pattern stream block: line stores, window, code.
// Depends on lbp_pkg.
//
// Usage:
//   Pixels enter in raster order on the input channel (i_in_valid / o_in_ready),
//   i_frame_start high on the first pixel of a frame. For each pixel at row r,
//   column c with r >= 2 and c >= 2, one result beat leaves on the output
//   channel (o_out_valid / i_out_ready) describing the centre pixel (r-1, c-1).
//   Border pixels produce no beat.
//   Configuration (tolerance, image width, image height) is written on the
//   plain write port while the block is idle; widths and heights are clamped
//   to [3, 1024].
//   Pipeline: an accepted pixel loads the compute stage, and the result
//   register is loaded from that stage when it retires, which a stall can delay.
//   Throughput: one pixel per cycle while the receiver takes beats; the two
//   line stores are single-write, single-read memories read at the incoming
//   column and written back when the compute stage retires, with forwarding when the same
//   column is read again right away.
//   Reset clears counters, window and pipeline valid bits; line store content
//   is left as is.
//   When the receiver stalls, the result register holds and the input stops
//   being accepted once the internal stage is full.
module lbp_3x3_descriptor_stream_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write port
    input  logic                        i_cfg_wr_en,
    input  logic [1:0]                  i_cfg_index,
    input  logic [lbp_pkg::DIM_W-1:0]   i_cfg_data,
    // Pixel input channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [lbp_pkg::PIX_W-1:0]   i_pixel_value,
    input  logic                        i_frame_start,
    // Result output channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [7:0]                  o_lbp_code,
    output logic [lbp_pkg::CLASS_W-1:0] o_pattern_class,
    output logic [lbp_pkg::POS_W-1:0]   o_centre_row,
    output logic [lbp_pkg::POS_W-1:0]   o_centre_col
);
    import lbp_pkg::*;

    // Configuration registers
    t_pix r_tolerance;
    t_dim r_width;
    t_dim r_height;

    // Position counters
    t_pos r_col;
    t_pos r_row;

    // Line stores: a holds row r-1, b holds row r-2
    t_pix r_line_a [MAX_WIDTH];
    t_pix r_line_b [MAX_WIDTH];
    t_pix r_rd_a;
    t_pix r_rd_b;

    // Window: 0..2 = top/mid/bottom at c-2, 3..5 = top/mid/bottom at c-1
    t_pix r_win [6];

    // Compute stage
    logic r_s1_valid;
    t_pix r_s1_px;
    t_pos r_s1_c;
    t_pos r_s1_r;
    logic r_s1_fwd;
    t_pix r_s1_fwd_top;
    t_pix r_s1_fwd_mid;

    // Output register
    logic                r_out_valid;
    logic [7:0]          r_out_code;
    logic [CLASS_W-1:0]  r_out_class;
    t_pos                r_out_row;
    t_pos                r_out_col;

    logic       in_acc;
    logic       s1_go;
    logic       s1_emit;
    t_pos       col_base, row_base, c0, r0;
    t_pos       n_col, n_row;
    t_dim       row_t, c1, r1;
    t_pix       s1_top, s1_mid;
    logic [8:0] thr;
    logic [7:0] code;

    function automatic t_dim clamp_dim(input t_dim v, input t_dim hi);
        t_dim res;
        if (v < DIM_W'(3)) begin
            res = DIM_W'(3);
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic ge_thr(input t_pix v, input logic [8:0] t);
        return {1'b0, v} >= t;
    endfunction

    // Handshake
    assign s1_go      = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_go;
    assign in_acc     = i_in_valid && o_in_ready;

    // Position of the arriving pixel, including frame start and geometry wrap
    always_comb begin
        col_base = i_frame_start ? '0 : r_col;
        row_base = i_frame_start ? '0 : r_row;
        if ({1'b0, col_base} >= r_width) begin
            c0    = '0;
            row_t = {1'b0, row_base} + DIM_W'(1);
        end else begin
            c0    = col_base;
            row_t = {1'b0, row_base};
        end
        r0 = (row_t >= r_height) ? '0 : row_t[POS_W-1:0];
        c1 = {1'b0, c0} + DIM_W'(1);
        r1 = {1'b0, r0} + DIM_W'(1);
        if (c1 >= r_width) begin
            n_col = '0;
            n_row = (r1 >= r_height) ? '0 : r1[POS_W-1:0];
        end else begin
            n_col = c1[POS_W-1:0];
            n_row = r0;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= '0;
            r_width     <= DIM_W'(640);
            r_height    <= DIM_W'(480);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_TOLERANCE:    r_tolerance <= i_cfg_data[PIX_W-1:0];
                CFG_IMAGE_WIDTH:  r_width  <= clamp_dim(i_cfg_data, DIM_W'(MAX_WIDTH));
                CFG_IMAGE_HEIGHT: r_height <= clamp_dim(i_cfg_data, DIM_W'(MAX_HEIGHT));
                default: ;
            endcase
        end
    end

    // Counters advance per accepted pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line store reads at the arriving column
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_a <= r_line_a[c0[ADDR_W-1:0]];
            r_rd_b <= r_line_b[c0[ADDR_W-1:0]];
        end
    end

    // Line store write-back when the compute stage retires
    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_line_a[r_s1_c[ADDR_W-1:0]] <= r_s1_px;
            r_line_b[r_s1_c[ADDR_W-1:0]] <= s1_mid;
        end
    end

    // Column read back-to-back with its own write-back takes the forwarded data
    assign s1_top = r_s1_fwd ? r_s1_fwd_top : r_rd_b;
    assign s1_mid = r_s1_fwd ? r_s1_fwd_mid : r_rd_a;

    // Compute stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_px      <= i_pixel_value;
            r_s1_c       <= c0;
            r_s1_r       <= r0;
            r_s1_fwd     <= r_s1_valid && (r_s1_c == c0);
            r_s1_fwd_top <= s1_mid;
            r_s1_fwd_mid <= r_s1_px;
        end
    end

    // Neighbour comparisons against centre plus tolerance
    assign thr = {1'b0, r_win[4]} + {1'b0, r_tolerance};
    always_comb begin
        code[7] = ge_thr(r_win[0], thr);
        code[6] = ge_thr(r_win[3], thr);
        code[5] = ge_thr(s1_top, thr);
        code[4] = ge_thr(r_win[1], thr);
        code[3] = ge_thr(s1_mid, thr);
        code[2] = ge_thr(r_win[2], thr);
        code[1] = ge_thr(r_win[5], thr);
        code[0] = ge_thr(r_s1_px, thr);
    end
    assign s1_emit = (r_s1_r >= POS_W'(2)) && (r_s1_c >= POS_W'(2));

    // Window shift on retire
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_go) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= s1_top;
            r_win[4] <= s1_mid;
            r_win[5] <= r_s1_px;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= s1_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_emit) begin
            r_out_code  <= code;
            r_out_class <= uniform_class(code);
            r_out_row   <= r_s1_r - POS_W'(1);
            r_out_col   <= r_s1_c - POS_W'(1);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_lbp_code      = r_out_code;
    assign o_pattern_class = r_out_class;
    assign o_centre_row    = r_out_row;
    assign o_centre_col    = r_out_col;

endmodule

>>> src/lbp_checker.sv
// Port-level checker for the 3x3 local binary pattern stream block, bound to the top.
// Depends on lbp_pkg and lbp_3x3_descriptor_stream_top.
module lbp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [7:0]                  o_lbp_code,
    input logic [lbp_pkg::CLASS_W-1:0] o_pattern_class,
    input logic [lbp_pkg::POS_W-1:0]   o_centre_row,
    input logic [lbp_pkg::POS_W-1:0]   o_centre_col
);
    import lbp_pkg::*;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_lbp_code)
            && $stable(o_centre_row) && $stable(o_centre_col))
        else $error("result beat changed while stalled");

    // Class agrees with the code it travels with
    a_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_pattern_class == uniform_class(o_lbp_code))
        else $error("pattern class does not match code");

    // Centre never sits on the border
    a_centre: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_centre_row >= POS_W'(1) && o_centre_col >= POS_W'(1)
            && o_centre_row <= POS_W'(MAX_HEIGHT - 2)
            && o_centre_col <= POS_W'(MAX_WIDTH - 2))
        else $error("centre position out of range");

    // Class range
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_pattern_class <= CLASS_FLAT)
        else $error("pattern class above 8");

endmodule

bind lbp_3x3_descriptor_stream_top lbp_checker u_lbp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_lbp_code      (o_lbp_code),
    .o_pattern_class (o_pattern_class),
    .o_centre_row    (o_centre_row),
    .o_centre_col    (o_centre_col)
);

>>> tb/sv/lbp_3x3_descriptor_stream_top_test.sv
// Self-checking testbench for lbp_3x3_descriptor_stream_top: directed frames, then random frames.
// Depends on lbp_pkg and the top level; a window model predicts beats the table does not fix.
module lbp_3x3_descriptor_stream_top_test;
    import lbp_pkg::*;

    localparam int CFG_SETTLE       = 4;      // two pipeline stages plus margin
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int HOLD_OFF_AT_BEAT = 150;
    localparam int RANDOM_PIXELS    = 1800;
    localparam int WIDE_PHASE       = 2;
    localparam int DIR_ROWS         = 32;

    typedef struct packed {
        logic [7:0]         code;
        logic [CLASS_W-1:0] cls;
        t_pos               row;
        t_pos               col;
    } t_lbp_beat;

    typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_PIX_KNOWN} t_row_kind;

    typedef struct packed {
        t_row_kind  kind;
        logic [1:0] index;
        t_dim       data;       // register value, or pixel in the low byte
        logic       fs;
        t_lbp_beat  known;
    } t_stim_row;

    localparam t_lbp_beat NO_BEAT    = '0;
    localparam t_lbp_beat FLAT_ONES  = '{code: 8'hFF, cls: CLASS_FLAT, row: 10'd1, col: 10'd1};
    localparam t_lbp_beat FLAT_ZEROS = '{code: 8'h00, cls: CLASS_FLAT, row: 10'd1, col: 10'd1};

    // Directed frames at the minimum 3x3 geometry
    localparam t_stim_row DIR_TABLE [DIR_ROWS] = '{
        // width 0 and height 1 clamp up to 3
        '{ROW_CFG, CFG_TOLERANCE,    11'd0, 1'b0, NO_BEAT},
        '{ROW_CFG, CFG_IMAGE_WIDTH,  11'd0, 1'b0, NO_BEAT},
        '{ROW_CFG, CFG_IMAGE_HEIGHT, 11'd1, 1'b0, NO_BEAT},
        // flat black frame: every neighbour equals the centre
        '{ROW_PIX,       2'd0, 11'd0, 1'b1, NO_BEAT},
        '{ROW_PIX,       2'd0, 11'd0, 1'b0, NO_BEAT},
        '{ROW_PIX,       2'd0, 11'd0, 1'b0, NO_BEAT},
        '{ROW_PIX,       2'd0, 11'd0, 1'b0, NO_BEAT},
        '{ROW_PIX,       2'd0, 11'd0, 1'b0, NO_BEAT},
        '{ROW_PIX,       2'd0, 11'd0, 1'b0, NO_BEAT},
        '{ROW_PIX,       2'd0, 11'd0, 1'b0, NO_BEAT},
        '{ROW_PIX,       2'd0, 11'd0, 1'b0, NO_BEAT},
        '{ROW_PIX_KNOWN, 2'd0, 11'd0, 1'b0, FLAT_ONES},
        // centre 1 plus tolerance 255 puts the threshold above any pixel
        '{ROW_CFG, CFG_TOLERANCE,    11'd255, 1'b0, NO_BEAT},
        '{ROW_PIX,       2'd0, 11'd255, 1'b1, NO_BEAT},
        '{ROW_PIX,       2'd0, 11'd255, 1'b0, NO_BEAT},
        '{ROW_PIX,       2'd0, 11'd255, 1'b0, NO_BEAT},
        '{ROW_PIX,       2'd0, 11'd255, 1'b0, NO_BEAT},
        '{ROW_PIX,       2'd0, 11'd1,   1'b0, NO_BEAT},
        '{ROW_PIX,       2'd0, 11'd255, 1'b0, NO_BEAT},
        '{ROW_PIX,       2'd0, 11'd255, 1'b0, NO_BEAT},
        '{ROW_PIX,       2'd0, 11'd255, 1'b0, NO_BEAT},
        '{ROW_PIX_KNOWN, 2'd0, 11'd255, 1'b0, FLAT_ZEROS},
        // checkerboard frame entered by wrap-around, no frame start
        '{ROW_CFG, CFG_TOLERANCE,    11'd0, 1'b0, NO_BEAT},
        '{ROW_PIX,       2'd0, 11'd200, 1'b0, NO_BEAT},
        '{ROW_PIX,       2'd0, 11'd10,  1'b0, NO_BEAT},
        '{ROW_PIX,       2'd0, 11'd200, 1'b0, NO_BEAT},
        '{ROW_PIX,       2'd0, 11'd10,  1'b0, NO_BEAT},
        '{ROW_PIX,       2'd0, 11'd100, 1'b0, NO_BEAT},
        '{ROW_PIX,       2'd0, 11'd10,  1'b0, NO_BEAT},
        '{ROW_PIX,       2'd0, 11'd200, 1'b0, NO_BEAT},
        '{ROW_PIX,       2'd0, 11'd10,  1'b0, NO_BEAT},
        '{ROW_PIX,       2'd0, 11'd200, 1'b0, NO_BEAT}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [1:0]         i_cfg_index;
    t_dim               i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    t_pix               i_pixel_value;
    logic               i_frame_start;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [7:0]         o_lbp_code;
    logic [CLASS_W-1:0] o_pattern_class;
    t_pos               o_centre_row;
    t_pos               o_centre_col;

    // Window model state
    t_pix      row_above  [MAX_WIDTH];
    t_pix      row_above2 [MAX_WIDTH];
    t_pix      win [6];
    int        col_cnt;
    int        row_cnt;
    int        geo_width;
    int        geo_height;
    t_pix      tol_val;

    t_lbp_beat expected_beats [$];
    int        n_errors;
    int        n_beats;

    lbp_3x3_descriptor_stream_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_pixel_value   (i_pixel_value),
        .i_frame_start   (i_frame_start),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_lbp_code      (o_lbp_code),
        .o_pattern_class (o_pattern_class),
        .o_centre_row    (o_centre_row),
        .o_centre_col    (o_centre_col)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int fit_dimension(input t_dim v, input int hi);
        if (v < 3) return 3;
        if (int'(v) > hi) return hi;
        return int'(v);
    endfunction

    // Length of the single circular run of ones, flat patterns give 8, the rest 0
    function automatic logic [CLASS_W-1:0] run_class(input logic [7:0] code);
        int ones;
        int runs;
        ones = 0;
        runs = 0;
        for (int i = 0; i < 8; i++) begin
            ones += code[i];
            if (code[i] && !code[(i + 1) % 8]) runs++;   // a run ends at bit i
        end
        if (code == 8'h00 || code == 8'hFF) return CLASS_FLAT;
        if (runs == 1) return CLASS_W'(ones);
        return CLASS_NONUNIFORM;
    endfunction

    // Advance the window model by one pixel; hit tells whether a beat is due
    task automatic predict_lbp_beat(input t_pix px, input logic fs, output logic hit,
                                    output t_lbp_beat beat);
        t_pix       top;
        t_pix       mid;
        logic [8:0] thr;
        logic [7:0] code;
        int         c;
        int         r;
        if (fs) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        // geometry may have shrunk under the counters
        if (col_cnt >= geo_width) begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= geo_height) row_cnt = 0;
        c   = col_cnt;
        r   = row_cnt;
        top = row_above2[c];
        mid = row_above[c];
        thr = {1'b0, win[4]} + {1'b0, tol_val};
        code = {({1'b0, win[0]} >= thr), ({1'b0, win[3]} >= thr), ({1'b0, top} >= thr),
                ({1'b0, win[1]} >= thr), ({1'b0, mid} >= thr),    ({1'b0, win[2]} >= thr),
                ({1'b0, win[5]} >= thr), ({1'b0, px} >= thr)};
        hit       = (r >= 2 && c >= 2);
        beat.code = code;
        beat.cls  = run_class(code);
        beat.row  = t_pos'(r - 1);
        beat.col  = t_pos'(c - 1);
        // shift stores and window
        row_above2[c] = mid;
        row_above[c]  = px;
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top;
        win[4] = mid;
        win[5] = px;
        col_cnt = c + 1;
        if (col_cnt >= geo_width) begin
            col_cnt = 0;
            row_cnt = r + 1;
            if (row_cnt >= geo_height) row_cnt = 0;
        end
    endtask

    task automatic write_reg(input logic [1:0] index, input t_dim value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        case (index)
            CFG_TOLERANCE:    tol_val    = value[7:0];
            CFG_IMAGE_WIDTH:  geo_width  = fit_dimension(value, MAX_WIDTH);
            CFG_IMAGE_HEIGHT: geo_height = fit_dimension(value, MAX_HEIGHT);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Stop offering pixels and wait until every beat is out and the pipe is empty
    task automatic drain_block();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(negedge i_clk);
        repeat (CFG_SETTLE) @(negedge i_clk);
    endtask

    task automatic send_pixel(input t_pix px, input logic fs, input int gap,
                              input logic use_known, input t_lbp_beat known);
        logic      hit;
        t_lbp_beat beat;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_pixel_value <= px;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_lbp_beat(px, fs, hit, beat);
        if (use_known) expected_beats = {expected_beats, known};
        else if (hit) expected_beats = {expected_beats, beat};
    endtask

    task automatic compare_field(input string label, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            n_errors++;
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, label, want, got);
        end
    endtask

    task automatic check_result_beat();
        t_lbp_beat want;
        if (expected_beats.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected beat: expected none, got code %0h class %0d at %0d,%0d",
                     $time, o_lbp_code, o_pattern_class, o_centre_row, o_centre_col);
        end else begin
            want = expected_beats.pop_front();
            compare_field("lbp_code",      32'(want.code), 32'(o_lbp_code));
            compare_field("pattern_class", 32'(want.cls),  32'(o_pattern_class));
            compare_field("centre_row",    32'(want.row),  32'(o_centre_row));
            compare_field("centre_col",    32'(want.col),  32'(o_centre_col));
        end
        n_beats++;
    endtask

    // Result side: random stalls in stretches, plus one long hold-off while pixels flow
    initial begin : result_sink
        int   stall;
        int   stall_max;
        int   beats_in_mode;
        logic held;
        i_out_ready   = 1'b0;
        stall_max     = 0;
        beats_in_mode = 0;
        held          = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (beats_in_mode == 0) begin
                stall_max     = ($urandom_range(0, 2) == 0) ? 0 : 7;
                beats_in_mode = 40;
            end
            if (!held && n_beats >= HOLD_OFF_AT_BEAT && i_in_valid === 1'b1) begin
                held  = 1'b1;
                stall = HOLD_OFF_CYCLES;
            end else begin
                stall = $urandom_range(0, stall_max);
            end
            if (stall > 0) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            check_result_beat();
            beats_in_mode--;
        end
    end

    initial begin : pixel_source
        int   phase;
        int   rows;
        int   n_pix;
        int   old_width;
        int   split;
        int   gap_max;
        int   pix_mode;
        int   lo;
        int   hi;
        int   v;
        int   rand_pixels;
        logic wide;
        logic wide_done;
        logic keep_going;
        logic fs;
        t_pix px;
        t_pix new_tol;
        t_dim new_w;
        t_dim new_h;

        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = CFG_TOLERANCE;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_pixel_value = '0;
        i_frame_start = 1'b0;
        n_errors      = 0;
        n_beats       = 0;

        // model state after reset
        for (int i = 0; i < MAX_WIDTH; i++) begin
            row_above[i]  = '0;
            row_above2[i] = '0;
        end
        for (int i = 0; i < 6; i++) win[i] = '0;
        col_cnt    = 0;
        row_cnt    = 0;
        tol_val    = '0;
        geo_width  = 640;
        geo_height = 480;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (DIR_TABLE[i].kind == ROW_CFG) begin
                drain_block();
                write_reg(DIR_TABLE[i].index, DIR_TABLE[i].data);
            end else begin
                send_pixel(DIR_TABLE[i].data[7:0], DIR_TABLE[i].fs, 0,
                           DIR_TABLE[i].kind == ROW_PIX_KNOWN, DIR_TABLE[i].known);
            end
        end

        // random phases: new geometry and tolerance, then mostly whole frames
        rand_pixels = 0;
        phase       = 0;
        wide_done   = 1'b0;
        while (rand_pixels < RANDOM_PIXELS) begin
            wide      = !wide_done && phase == WIDE_PHASE;
            old_width = geo_width;
            drain_block();

            case ($urandom_range(0, 3))
                0:       new_tol = '0;
                1:       new_tol = 8'hFF;
                2:       new_tol = t_pix'($urandom_range(0, 15));
                default: new_tol = t_pix'($urandom_range(0, 255));
            endcase
            if (wide)
                new_w = t_dim'($urandom_range(200, 400));
            else if ($urandom_range(0, 9) == 0)
                new_w = t_dim'($urandom_range(0, 3));
            else if ($urandom_range(0, 7) == 0)
                new_w = t_dim'($urandom_range(17, 48));
            else
                new_w = t_dim'($urandom_range(3, 16));
            if (wide) begin
                new_h = 11'd3;
            end else begin
                case ($urandom_range(0, 9))
                    0:       new_h = t_dim'($urandom_range(0, 2));
                    1:       new_h = $urandom_range(0, 1) ? 11'd1024 : 11'h7FF;
                    default: new_h = t_dim'($urandom_range(3, 8));
                endcase
            end
            write_reg(CFG_TOLERANCE, {3'b000, new_tol});
            write_reg(CFG_IMAGE_WIDTH, new_w);
            write_reg(CFG_IMAGE_HEIGHT, new_h);

            // a wider row would read store entries never written: restart the frame then
            keep_going = (geo_width <= old_width) && ($urandom_range(0, 3) == 0);

            rows  = (geo_height > 64) ? $urandom_range(3, 24) : geo_height;
            n_pix = geo_width * rows * $urandom_range(1, 2);
            if ($urandom_range(0, 3) == 0) n_pix += $urandom_range(1, geo_width * rows);
            if (n_pix > 600) n_pix = 600;
            if (wide) n_pix = 2 * geo_width + 40;

            pix_mode = $urandom_range(0, 3);
            lo       = $urandom_range(0, 255);
            hi       = $urandom_range(0, 255);
            if ($urandom_range(0, 3) == 0) begin
                lo = 0;
                hi = 255;
            end
            split   = $urandom_range(0, geo_width);
            gap_max = ($urandom_range(0, 2) == 0) ? 0 : 7;

            for (int k = 0; k < n_pix; k++) begin
                case (pix_mode)
                    0: px = t_pix'($urandom_range(0, 255));
                    1: begin
                        // small noise around one level, so tolerance decides the bits
                        v = lo + int'($urandom_range(0, 12)) - 6;
                        if (v < 0) v = 0;
                        if (v > 255) v = 255;
                        px = t_pix'(v);
                    end
                    2: px = t_pix'($urandom_range(0, 1) ? hi : lo);
                    default: px = t_pix'(((k % geo_width) < split) ? lo : hi);
                endcase
                fs = (k == 0 && !keep_going) || ($urandom_range(0, 79) == 0);
                send_pixel(px, fs, $urandom_range(0, gap_max), 1'b0, NO_BEAT);
                rand_pixels++;
            end
            if (wide) wide_done = 1'b1;
            phase++;
        end

        drain_block();
        repeat (8) @(posedge i_clk);
        if (n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
